>>> src/text_terminal_writer_assert.svh
// Assertion macros shared by the text terminal writer modules.
// No dependencies; included by files that carry concurrent checks.
`ifndef TEXT_TERMINAL_WRITER_ASSERT_SVH
`define TEXT_TERMINAL_WRITER_ASSERT_SVH

// condition holds at every rising clock edge outside reset
`define TT_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define TT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define TT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/tt_pkg.sv
// Package for the text terminal writer: screen geometry, item and command types,
// action codes and back-end states. No dependencies.
`default_nettype none

package tt_pkg;

  // screen geometry
  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int ADDR_W         = $clog2(CELL_COUNT);

  // field widths of the item ports
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;

  // character codes and reset color
  localparam logic [7:0] NEWLINE_CODE     = 8'd10;
  localparam logic [7:0] BLANK_CODE       = 8'd32;
  localparam logic [7:0] TEXT_COLOR_RESET = 8'd7;

  // command queue depth
  localparam int FIFO_DEPTH = 2;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef struct packed {
    action_t          action;
    logic [7:0]       char_code;
    logic [7:0]       cell_color;
    logic [COL_W-1:0] pos_col;
    logic [ROW_W-1:0] pos_row;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;
  } out_item_t;

  // classified command passed from front to back
  typedef struct packed {
    logic              write_en;
    logic              scroll;
    logic              clear;
    logic              read;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CELL_W-1:0] cell_word;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_FILL,
    BK_DONE
  } back_state_t;

endpackage

`default_nettype wire

>>> src/text_terminal_writer.sv
// Text terminal writer: the back end takes each item through pop, execute and
// result (states BK_IDLE, BK_EXEC, BK_DONE) before popping the next; the command
// queue lets the front accept up to two more items meanwhile. A character written
// into a blanked row first fills every cell of that row with a blank, then is
// executed again. Scroll and clear mark rows blank by flag. Synchronous reset: cursor home,
// text color 7, whole screen reads blank; no clearing pass.
`default_nettype none

module text_terminal_writer
  import tt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item,
  input  logic       cfg_wen,
  input  logic [7:0] cfg_wdata
);

  logic       full;
  logic       empty;
  logic       push;
  logic       pop;
  cmd_t       push_cmd;
  cmd_t       head;
  logic [7:0] text_color;

  // item intake and classification
  tt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .text_color(text_color),
    .full      (full),
    .push      (push),
    .cmd       (push_cmd)
  );

  // command queue
  tt_cmd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .full    (full),
    .empty   (empty)
  );

  // screen execution and results
  tt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .text_color(text_color),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

>>> src/tt_front.sv
// Front end: accepts items, tracks the cursor and the text color register,
// and turns each item into a command for the queue. Depends on tt_pkg.
`default_nettype none

module tt_front
  import tt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  input  logic       cfg_wen,
  input  logic [7:0] cfg_wdata,
  output logic [7:0] text_color,
  input  logic       full,
  output logic       push,
  output cmd_t       cmd
);

  logic [ROW_W-1:0] cursor_row;
  logic [ROW_W-1:0] cursor_row_next;
  logic [COL_W-1:0] cursor_col;
  logic [COL_W-1:0] cursor_col_next;
  logic             in_range;
  logic             last_row;
  logic             last_col;

  // handshake: stall only when the queue is full
  assign in_stall = full;
  assign push     = in_valid && !full;

  assign in_range = (in_item.pos_col < COL_W'(SCREEN_COLUMNS)) &&
                    (in_item.pos_row < ROW_W'(SCREEN_ROWS));
  assign last_row = (cursor_row == ROW_W'(SCREEN_ROWS - 1));
  assign last_col = (cursor_col == COL_W'(SCREEN_COLUMNS - 1));

  // classify the item and step the cursor
  always_comb begin
    cursor_row_next = cursor_row;
    cursor_col_next = cursor_col;
    cmd             = '0;
    unique case (in_item.action)
      ACT_PUT: begin
        if (in_item.char_code == NEWLINE_CODE) begin
          cursor_col_next = '0;
          if (last_row) begin
            cmd.scroll = 1'b1;
          end else begin
            cursor_row_next = cursor_row + ROW_W'(1);
          end
        end else begin
          cmd.write_en  = 1'b1;
          cmd.row       = cursor_row;
          cmd.col       = cursor_col;
          cmd.cell_word = {text_color, in_item.char_code};
          if (last_col) begin
            cursor_col_next = '0;
            if (last_row) begin
              cmd.scroll = 1'b1;
            end else begin
              cursor_row_next = cursor_row + ROW_W'(1);
            end
          end else begin
            cursor_col_next = cursor_col + COL_W'(1);
          end
        end
      end
      ACT_WRITE: begin
        cmd.write_en  = in_range;
        cmd.row       = in_item.pos_row;
        cmd.col       = in_item.pos_col;
        cmd.cell_word = {in_item.cell_color, in_item.char_code};
      end
      ACT_CLEAR: begin
        cmd.clear       = 1'b1;
        cursor_row_next = '0;
        cursor_col_next = '0;
      end
      ACT_READ: begin
        cmd.read = in_range;
        cmd.row  = in_item.pos_row;
        cmd.col  = in_item.pos_col;
      end
      default: begin
        cmd = '0;
      end
    endcase
    cmd.cursor_row = cursor_row_next;
    cmd.cursor_col = cursor_col_next;
  end

  // cursor and color registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_row <= '0;
      cursor_col <= '0;
      text_color <= TEXT_COLOR_RESET;
    end else begin
      if (push) begin
        cursor_row <= cursor_row_next;
        cursor_col <= cursor_col_next;
      end
      if (cfg_wen) begin
        text_color <= cfg_wdata;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/tt_cmd_fifo.sv
// Short command queue between the front and back ends of the terminal writer.
// Depends on tt_pkg and the assertion macro header.
`default_nettype none
`include "text_terminal_writer_assert.svh"

module tt_cmd_fifo
  import tt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  cmd_t             entries [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `TT_ASSERT_IMPLY(a_no_push_full, clk, rst, full, !push, "push into full command queue")
  `TT_ASSERT_IMPLY(a_no_pop_empty, clk, rst, empty, !pop, "pop from empty command queue")
  `TT_ASSERT_ALWAYS(a_count_range, clk, rst, count <= CNT_W'(FIFO_DEPTH), "queue count overflow")

endmodule

`default_nettype wire

>>> src/tt_back.sv
// Back end: executes commands on the screen memory (rotating row origin,
// per-row blank flags) and holds the result register. Depends on tt_pkg and macros.
`default_nettype none
`include "text_terminal_writer_assert.svh"

module tt_back
  import tt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] text_color,
  input  logic       empty,
  input  cmd_t       head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item
);

  back_state_t       state;
  back_state_t       state_next;
  cmd_t              cur;
  logic [ROW_W-1:0]  top;
  logic              row_blank [SCREEN_ROWS];
  logic [7:0]        row_color [SCREEN_ROWS];
  logic [COL_W-1:0]  fill_cnt;
  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] rd_data;
  logic              rd_blank;
  logic [7:0]        rd_color;

  logic [ROW_W:0]    row_sum;
  logic [ROW_W-1:0]  prow;
  logic [ADDR_W-1:0] row_base;
  logic [ADDR_W-1:0] mem_addr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_we;
  logic              mem_re;
  logic              cur_blank;
  logic              fill_start;
  logic              fill_last;
  logic              do_scroll;
  logic              do_clear;
  logic              out_load;
  logic [CELL_W-1:0] result_data;

  // logical row to physical row through the rotating origin
  assign row_sum  = {1'b0, cur.row} + {1'b0, top};
  assign prow     = (row_sum >= (ROW_W + 1)'(SCREEN_ROWS)) ?
                    ROW_W'(row_sum - (ROW_W + 1)'(SCREEN_ROWS)) : ROW_W'(row_sum);
  assign row_base = ADDR_W'(prow) * ADDR_W'(SCREEN_COLUMNS);
  assign cur_blank = row_blank[prow];
  assign fill_last = (fill_cnt == COL_W'(SCREEN_COLUMNS - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (!empty) state_next = BK_EXEC;
      BK_EXEC: state_next = fill_start ? BK_FILL : BK_DONE;
      BK_FILL: if (fill_last) state_next = BK_EXEC;
      BK_DONE: if (out_load) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop        = (state == BK_IDLE) && !empty;
    fill_start = (state == BK_EXEC) && cur.write_en && cur_blank;
    mem_we     = (state == BK_FILL) || ((state == BK_EXEC) && cur.write_en && !cur_blank);
    mem_re     = (state == BK_EXEC) && cur.read;
    do_scroll  = (state == BK_EXEC) && cur.scroll && !fill_start;
    do_clear   = (state == BK_EXEC) && cur.clear;
    out_load   = (state == BK_DONE) && (!out_valid || !out_stall);
    if (state == BK_FILL) begin
      mem_addr  = row_base + ADDR_W'(fill_cnt);
      mem_wdata = {row_color[prow], BLANK_CODE};
    end else begin
      mem_addr  = row_base + ADDR_W'(cur.col);
      mem_wdata = cur.cell_word;
    end
    if (!cur.read) begin
      result_data = '0;
    end else if (rd_blank) begin
      result_data = {rd_color, BLANK_CODE};
    end else begin
      result_data = rd_data;
    end
  end

  // screen memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_addr];
    end
  end

  // command, read side info and fill counter
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (mem_re) begin
      rd_blank <= cur_blank;
      rd_color <= row_color[prow];
    end
    if (fill_start) begin
      fill_cnt <= '0;
    end else if (state == BK_FILL) begin
      fill_cnt <= fill_cnt + COL_W'(1);
    end
  end

  // state, row origin and row blank flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      top   <= '0;
      for (int r = 0; r < SCREEN_ROWS; r++) begin
        row_blank[r] <= 1'b1;
        row_color[r] <= TEXT_COLOR_RESET;
      end
    end else begin
      state <= state_next;
      if (do_clear) begin
        for (int r = 0; r < SCREEN_ROWS; r++) begin
          row_blank[r] <= 1'b1;
          row_color[r] <= text_color;
        end
      end else begin
        if ((state == BK_FILL) && fill_last) begin
          row_blank[prow] <= 1'b0;
        end
        if (do_scroll) begin
          row_blank[top] <= 1'b1;
          row_color[top] <= text_color;
          top <= (top == ROW_W'(SCREEN_ROWS - 1)) ? '0 : top + ROW_W'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item.cursor_row <= cur.cursor_row;
      out_item.cursor_col <= cur.cursor_col;
      out_item.cell_data  <= result_data;
      out_item.scrolled   <= cur.scroll;
    end
  end

  `TT_ASSERT_ALWAYS(a_top_range, clk, rst, int'(top) < SCREEN_ROWS, "row origin out of range")
  `TT_ASSERT_NEXT(a_fill_exit, clk, rst, state == BK_FILL, state == BK_FILL || state == BK_EXEC, "fill left to wrong state")
  `TT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_item), "result changed while stalled")

endmodule

`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for text_terminal_writer: screen store, cursor, scroll and clear.
// Depends on tt_pkg for the item types, the action codes and the screen geometry.
// A clocked driver and monitor run against a local screen predictor.

module tb;
  import tt_pkg::*;

  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 120;
  localparam int REPORT_LIMIT  = 10;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_item = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;
  logic       cfg_wen = 1'b0;
  logic [7:0] cfg_wdata = '0;

  // predicted terminal state
  logic [CELL_W-1:0] screen_m [CELL_COUNT];
  int                cur_row_m;
  int                cur_col_m;
  logic [7:0]        text_color_m;

  in_item_t  items_to_send[$];
  out_item_t expected_results[$];

  int fail_count    = 0;
  int result_count  = 0;
  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int hold_requests = 0;

  text_terminal_writer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // screen predictor
  function automatic void blank_screen();
    for (int i = 0; i < CELL_COUNT; i++) screen_m[i] = {text_color_m, BLANK_CODE};
  endfunction

  function automatic bit move_down();
    if (cur_row_m == SCREEN_ROWS - 1) begin
      for (int i = 0; i < CELL_COUNT - SCREEN_COLUMNS; i++)
        screen_m[i] = screen_m[i + SCREEN_COLUMNS];
      for (int i = CELL_COUNT - SCREEN_COLUMNS; i < CELL_COUNT; i++)
        screen_m[i] = {text_color_m, BLANK_CODE};
      return 1'b1;
    end
    cur_row_m++;
    return 1'b0;
  endfunction

  function automatic out_item_t terminal_step(in_item_t it);
    out_item_t res;
    bit        in_range;
    int        addr;
    res = '0;
    in_range = (it.pos_col < SCREEN_COLUMNS) && (it.pos_row < SCREEN_ROWS);
    addr = it.pos_row * SCREEN_COLUMNS + it.pos_col;
    case (it.action)
      ACT_PUT: begin
        if (it.char_code == NEWLINE_CODE) begin
          cur_col_m = 0;
          res.scrolled = move_down();
        end else begin
          screen_m[cur_row_m * SCREEN_COLUMNS + cur_col_m] = {text_color_m, it.char_code};
          if (cur_col_m == SCREEN_COLUMNS - 1) begin
            cur_col_m = 0;
            res.scrolled = move_down();
          end else begin
            cur_col_m++;
          end
        end
      end
      ACT_WRITE: begin
        if (in_range) screen_m[addr] = {it.cell_color, it.char_code};
      end
      ACT_CLEAR: begin
        blank_screen();
        cur_row_m = 0;
        cur_col_m = 0;
      end
      default: begin
        if (in_range) res.cell_data = screen_m[addr];
      end
    endcase
    res.cursor_row = cur_row_m[ROW_W-1:0];
    res.cursor_col = cur_col_m[COL_W-1:0];
    return res;
  endfunction

  // gap length: mostly none or short, sometimes long
  function automatic int pick_gap(int pct);
    if (pct == 0 || $urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // input driver
  always @(posedge clk) begin : driver
    int idle_left;
    if (rst) begin
      in_valid <= 1'b0;
      idle_left = 0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(terminal_step(in_item));
      if (!(in_valid && in_stall)) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (items_to_send.size() > 0) begin
          in_item <= items_to_send.pop_front();
          in_valid <= 1'b1;
          idle_left = pick_gap(in_idle_pct);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin : monitor
    int stall_left;
    int holds_served;
    int n;
    out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
      holds_served = 0;
    end else begin
      if (out_valid && !out_stall) begin
        result_count++;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("result %0d: unexpected item %h", result_count, out_item);
        end else begin
          want = expected_results.pop_front();
          if (out_item.cursor_row !== want.cursor_row ||
              out_item.cursor_col !== want.cursor_col ||
              out_item.cell_data  !== want.cell_data ||
              out_item.scrolled   !== want.scrolled) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("result %0d: expected row %0d col %0d cell %h scr %b, got row %0d col %0d cell %h scr %b",
                       result_count, want.cursor_row, want.cursor_col, want.cell_data,
                       want.scrolled, out_item.cursor_row, out_item.cursor_col,
                       out_item.cell_data, out_item.scrolled);
          end
        end
      end
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        stall_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        n = pick_gap(out_stall_pct);
        out_stall <= (n > 0);
        stall_left = (n > 0) ? n - 1 : 0;
      end
    end
  end

  // stimulus helpers
  function automatic in_item_t make_item(action_t act, logic [7:0] ch, logic [7:0] color,
                                         logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
    in_item_t it;
    it.action     = act;
    it.char_code  = ch;
    it.cell_color = color;
    it.pos_col    = col;
    it.pos_row    = row;
    return it;
  endfunction

  function automatic in_item_t put_item(logic [7:0] ch);
    return make_item(ACT_PUT, ch, 8'($urandom), 7'($urandom), 5'($urandom));
  endfunction

  function automatic logic [COL_W-1:0] pick_col(bit wild);
    return wild ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, SCREEN_COLUMNS - 1));
  endfunction

  function automatic logic [ROW_W-1:0] pick_row(bit wild);
    return wild ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, SCREEN_ROWS - 1));
  endfunction

  // text runs, write/read-back pairs, reads, long lines, clears and noise
  task automatic queue_mixed(input int n);
    int sent;
    int kind;
    int len;
    bit wild;
    logic [COL_W-1:0] c;
    logic [ROW_W-1:0] r;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        len = $urandom_range(1, 12);
        repeat (len)
          items_to_send.push_back(put_item(($urandom_range(0, 99) < 20) ?
                                           NEWLINE_CODE : 8'($urandom_range(0, 255))));
        sent += len;
      end else if (kind < 70) begin
        wild = ($urandom_range(0, 9) == 0);
        c = pick_col(wild);
        r = pick_row(wild);
        items_to_send.push_back(make_item(ACT_WRITE, 8'($urandom), 8'($urandom), c, r));
        items_to_send.push_back(make_item(ACT_READ, 8'($urandom), 8'($urandom), c, r));
        sent += 2;
      end else if (kind < 88) begin
        wild = ($urandom_range(0, 6) == 0);
        items_to_send.push_back(make_item(ACT_READ, 8'($urandom), 8'($urandom),
                                          pick_col(wild), pick_row(wild)));
        sent++;
      end else if (kind < 92) begin
        len = $urandom_range(70, 90);
        repeat (len) items_to_send.push_back(put_item(8'($urandom_range(32, 126))));
        sent += len;
      end else if (kind < 94) begin
        items_to_send.push_back(make_item(ACT_CLEAR, 8'($urandom), 8'($urandom),
                                          7'($urandom), 5'($urandom)));
        sent++;
      end else begin
        items_to_send.push_back(make_item(action_t'($urandom_range(0, 3)), 8'($urandom),
                                          8'($urandom), 7'($urandom), 5'($urandom)));
        sent++;
      end
    end
  endtask

  // block is idle once every queued item has its result
  task automatic wait_idle();
    do @(negedge clk);
    while (items_to_send.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  task automatic write_text_color(input logic [7:0] color);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= color;
    text_color_m = color;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // main sequence
  initial begin
    text_color_m = TEXT_COLOR_RESET;
    cur_row_m = 0;
    cur_col_m = 0;
    blank_screen();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset contents in the reset color
    in_idle_pct = 30;
    out_stall_pct = 30;
    items_to_send.push_back(make_item(ACT_READ, 8'h00, 8'h00, 7'd0, 5'd0));
    items_to_send.push_back(make_item(ACT_READ, 8'hFF, 8'hFF, 7'd79, 5'd24));
    wait_idle();
    write_text_color(8'h1E);

    // directed: field extremes, newline, out-of-range cells, clear color
    items_to_send.push_back(put_item(8'h41));
    items_to_send.push_back(put_item(8'hFF));
    items_to_send.push_back(put_item(8'h00));
    items_to_send.push_back(put_item(NEWLINE_CODE));
    items_to_send.push_back(make_item(ACT_WRITE, NEWLINE_CODE, 8'hFF, 7'd79, 5'd24));
    items_to_send.push_back(make_item(ACT_WRITE, 8'hFF, 8'h00, 7'd0, 5'd1));
    items_to_send.push_back(make_item(ACT_WRITE, 8'h55, 8'h55, 7'd80, 5'd0));
    items_to_send.push_back(make_item(ACT_WRITE, 8'h55, 8'h55, 7'd0, 5'd25));
    items_to_send.push_back(make_item(ACT_WRITE, 8'h00, 8'hFF, 7'd127, 5'd31));
    items_to_send.push_back(make_item(ACT_READ, 8'h00, 8'h00, 7'd0, 5'd0));
    items_to_send.push_back(make_item(ACT_READ, 8'h00, 8'h00, 7'd1, 5'd0));
    items_to_send.push_back(make_item(ACT_READ, 8'h00, 8'h00, 7'd2, 5'd0));
    items_to_send.push_back(make_item(ACT_READ, 8'h00, 8'h00, 7'd79, 5'd24));
    items_to_send.push_back(make_item(ACT_READ, 8'h00, 8'h00, 7'd0, 5'd1));
    items_to_send.push_back(make_item(ACT_READ, 8'h00, 8'h00, 7'd80, 5'd0));
    items_to_send.push_back(make_item(ACT_READ, 8'hFF, 8'hFF, 7'd127, 5'd31));
    items_to_send.push_back(make_item(ACT_READ, 8'h00, 8'h00, 7'd0, 5'd25));
    items_to_send.push_back(make_item(ACT_CLEAR, 8'hA5, 8'h5A, 7'd99, 5'd17));
    items_to_send.push_back(make_item(ACT_READ, 8'h00, 8'h00, 7'd5, 5'd5));
    items_to_send.push_back(make_item(ACT_READ, 8'h00, 8'h00, 7'd79, 5'd24));
    items_to_send.push_back(make_item(ACT_PUT, 8'h7F, 8'hFF, 7'd127, 5'd31));
    items_to_send.push_back(make_item(ACT_READ, 8'hFF, 8'hFF, 7'd0, 5'd0));
    queue_mixed(150);
    wait_idle();

    // back-to-back with no idling, black attribute
    write_text_color(8'h00);
    in_idle_pct = 0;
    out_stall_pct = 0;
    queue_mixed(120);
    wait_idle();

    // long receiver hold while the sender keeps offering
    write_text_color(8'hFF);
    out_stall_pct = 20;
    hold_requests++;
    queue_mixed(80);
    wait_idle();

    // heavy idling on both sides
    write_text_color(8'($urandom_range(1, 254)));
    in_idle_pct = 50;
    out_stall_pct = 50;
    queue_mixed(150);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit
  initial begin
    #(8 * 1_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> text_terminal_writer.f
+incdir+src
src/tt_pkg.sv
src/tt_front.sv
src/tt_cmd_fifo.sv
src/tt_back.sv
src/text_terminal_writer.sv
verif/tb.sv
